[src/amsg_pkg.sv]
package amsg_pkg;

	localparam int ACCEL_W     = 16;
	localparam int THRESH_W    = 16;
	localparam int LIMIT_W     = 8;
	localparam int MAG_W       = 16;
	localparam int SQ_W        = 32;
	localparam int AVG_SUM_W   = 19;
	localparam int ROOT_STEPS  = 16;
	localparam int STEP_W      = 4;
	localparam int AVG_TAPS_DEF = 5;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MID_THRESH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd3;

	localparam logic [THRESH_W-1:0] LOW_THRESH_RST  = 16'd900;
	localparam logic [THRESH_W-1:0] HIGH_THRESH_RST = 16'd1100;
	localparam logic [THRESH_W-1:0] MID_THRESH_RST  = 16'd1000;
	localparam logic [LIMIT_W-1:0]  TIMEOUT_RST     = 8'd50;

	localparam logic [LIMIT_W-1:0]  COUNT_MAX = '1;
	localparam logic [SQ_W-1:0]     ROOT_BIT_INIT = 32'h4000_0000;

endpackage

[src/amsg_if.sv]
interface amsg_in_if;
	import amsg_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [ACCEL_W-1:0] accel_x;
	logic signed [ACCEL_W-1:0] accel_y;
	logic signed [ACCEL_W-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface amsg_out_if;
	import amsg_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 motion_done;
	logic                 timed_out;
	logic                 recorded;
	logic [AVG_SUM_W-1:0] average_sum;

	modport source (output valid, output motion_done, output timed_out, output recorded,
		output average_sum, input ready);
	modport sink (input valid, input motion_done, input timed_out, input recorded,
		input average_sum, output ready);
endinterface

[src/accel_motion_segmenter_top.sv]
// Channel     Dir  Beat contents
// sample_in   in   accel_x, accel_y, accel_z (signed 16 bit)
// result_out  out  motion_done, timed_out, recorded, average_sum (19 bit)
// cfg_*       in   cfg_wr_en, cfg_index, cfg_wdata (one register per write)
//
// After accept, a sample passes through the multiply-accumulate steps for the squared
// length, the shared restoring square root steps (the history sum accumulates
// alongside), and a decision state.
// sample_in.ready is high only while the sequencer is idle; the result sits in an
// output register, so the next sample may enter while it waits to be taken.
// A stalled result holds the sequencer in its decision cycle.
// arst_n clears thresholds to their defaults and empties the history.
module accel_motion_segmenter_top #(
	parameter int AVERAGE_TAPS = amsg_pkg::AVG_TAPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	amsg_in_if.sink                              sample_in,
	amsg_out_if.source                           result_out,
	input  logic                                 cfg_wr_en,
	input  logic [amsg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [amsg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import amsg_pkg::*;

	localparam int HIST_DEPTH = AVERAGE_TAPS + 1;
	localparam int HIDX_W     = $clog2(HIST_DEPTH);
	localparam int WARM_W     = $clog2(HIST_DEPTH + 1);
	localparam int SUM_W      = MAG_W + $clog2(AVERAGE_TAPS + 1);
	localparam int EXT_W      = (SUM_W > AVG_SUM_W) ? SUM_W : AVG_SUM_W;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SQ     = 5'b00010,
		S_ROOT   = 5'b00100,
		S_DECIDE = 5'b01000,
		S_SPARE  = 5'b10000
	} state_t;

	state_t state_q;

	logic [THRESH_W-1:0] low_q, high_q, mid_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic [ACCEL_W-1:0]  ax_q, ay_q, az_q;
	logic [STEP_W-1:0]   step_q;
	logic [SQ_W-1:0]     acc_q;
	logic [SQ_W-1:0]     root_q;
	logic [SQ_W-1:0]     bit_q;
	logic [HIDX_W-1:0]   tap_q;
	logic [SUM_W-1:0]    sum_q;

	logic [MAG_W-1:0]    hist_q [HIST_DEPTH];
	logic [WARM_W-1:0]   warm_q;
	logic                start_q, middle_q, seek_low_q;
	logic [LIMIT_W-1:0]  count_q;

	logic                 out_valid_q, out_done_q, out_tout_q, out_rec_q;
	logic [AVG_SUM_W-1:0] out_sum_q;

	// shared arithmetic
	logic [ACCEL_W-1:0]  mul_op;
	logic [SQ_W-1:0]     prod;
	logic [SQ_W-1:0]     trial;
	logic                fits;
	logic [HIDX_W-1:0]   tap_idx;

	logic                accept, out_free, decide_go;

	always_comb begin
		case (step_q[1:0])
			2'd0:    mul_op = ax_q;
			2'd1:    mul_op = ay_q;
			default: mul_op = az_q;
		endcase
		prod    = SQ_W'(mul_op) * SQ_W'(mul_op);
		trial   = root_q + bit_q;
		fits    = (acc_q >= trial);
		tap_idx = tap_q + HIDX_W'(1);
	end

	assign accept    = sample_in.valid && sample_in.ready;
	assign out_free  = !out_valid_q || result_out.ready;
	assign decide_go = (state_q == S_DECIDE) && out_free;
	assign sample_in.ready = (state_q == S_IDLE);

	function automatic logic [ACCEL_W-1:0] abs_val(input logic signed [ACCEL_W-1:0] v);
		abs_val = v[ACCEL_W-1] ? ACCEL_W'(-v) : ACCEL_W'(v);
	endfunction

	// decision for each new sample, made on the history sum without its magnitude
	logic [SUM_W-1:0] lo_x, hi_x, mid_x;
	logic             warm_done;
	logic             n_start, n_middle, n_seek_low, r_done, r_tout, r_rec;
	logic [LIMIT_W-1:0] n_count;
	logic [EXT_W-1:0] sum_ext;

	always_comb begin
		lo_x       = SUM_W'(low_q) * SUM_W'(AVERAGE_TAPS);
		hi_x       = SUM_W'(high_q) * SUM_W'(AVERAGE_TAPS);
		mid_x      = SUM_W'(mid_q) * SUM_W'(AVERAGE_TAPS);
		warm_done  = (warm_q == WARM_W'(HIST_DEPTH));
		n_start    = start_q;
		n_middle   = middle_q;
		n_seek_low = seek_low_q;
		n_count    = count_q;
		r_done     = 1'b0;
		r_tout     = 1'b0;
		r_rec      = 1'b0;
		sum_ext    = EXT_W'(sum_q);
		if (count_q > limit_q) begin
			n_start  = 1'b0;
			n_middle = 1'b0;
			r_done   = 1'b1;
			r_tout   = 1'b1;
		end else if (!start_q) begin
			if (sum_q <= lo_x) begin
				n_start    = 1'b1;
				n_seek_low = 1'b0;
				r_rec      = 1'b1;
			end else if (sum_q >= hi_x) begin
				n_start    = 1'b1;
				n_seek_low = 1'b1;
				r_rec      = 1'b1;
			end
		end else if (!middle_q) begin
			r_rec = 1'b1;
			if (seek_low_q ? (sum_q <= mid_x) : (sum_q >= mid_x))
				n_middle = 1'b1;
		end else begin
			r_rec = 1'b1;
			if (seek_low_q ? (sum_q >= mid_x) : (sum_q <= mid_x)) begin
				n_start  = 1'b0;
				n_middle = 1'b0;
				r_done   = 1'b1;
			end
		end
		if (r_done)
			n_count = '0;
		else if (r_rec && count_q != COUNT_MAX)
			n_count = count_q + LIMIT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= LOW_THRESH_RST;
			high_q  <= HIGH_THRESH_RST;
			mid_q   <= MID_THRESH_RST;
			limit_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOW_THRESH:  low_q   <= cfg_wdata;
				REG_HIGH_THRESH: high_q  <= cfg_wdata;
				REG_MID_THRESH:  mid_q   <= cfg_wdata;
				REG_TIMEOUT:     limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			warm_q      <= '0;
			start_q     <= 1'b0;
			middle_q    <= 1'b0;
			seek_low_q  <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HIST_DEPTH; i++)
				hist_q[i] <= '0;
		end else begin
			if (decide_go)
				out_valid_q <= 1'b1;
			else if (result_out.valid && result_out.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (step_q == STEP_W'(2)) begin
						step_q  <= '0;
						state_q <= S_ROOT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_ROOT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_STEPS - 1))
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (out_free) begin
						// push the new magnitude, oldest drops off
						for (int i = 0; i < HIST_DEPTH - 1; i++)
							hist_q[i] <= hist_q[i + 1];
						hist_q[HIST_DEPTH-1] <= root_q[MAG_W-1:0];
						if (!warm_done) begin
							warm_q <= warm_q + WARM_W'(1);
						end else begin
							start_q    <= n_start;
							middle_q   <= n_middle;
							seek_low_q <= n_seek_low;
							count_q    <= n_count;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: squares, root iterations, history sum, result register
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q  <= abs_val(sample_in.accel_x);
			ay_q  <= abs_val(sample_in.accel_y);
			az_q  <= abs_val(sample_in.accel_z);
			acc_q <= '0;
		end
		if (state_q == S_SQ) begin
			acc_q  <= acc_q + prod;
			root_q <= '0;
			bit_q  <= ROOT_BIT_INIT;
			tap_q  <= '0;
			sum_q  <= '0;
		end
		if (state_q == S_ROOT) begin
			if (fits) begin
				acc_q  <= acc_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
			// oldest taps after the push are entries 1..AVERAGE_TAPS now
			if (tap_q != HIDX_W'(AVERAGE_TAPS)) begin
				sum_q <= sum_q + SUM_W'(hist_q[tap_idx]);
				tap_q <= tap_idx;
			end
		end
		if (decide_go) begin
			if (!warm_done) begin
				out_done_q <= 1'b0;
				out_tout_q <= 1'b0;
				out_rec_q  <= 1'b0;
				out_sum_q  <= '0;
			end else begin
				out_done_q <= r_done;
				out_tout_q <= r_tout;
				out_rec_q  <= r_rec;
				out_sum_q  <= sum_ext[AVG_SUM_W-1:0];
			end
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.motion_done = out_done_q;
	assign result_out.timed_out   = out_tout_q;
	assign result_out.recorded    = out_rec_q;
	assign result_out.average_sum = out_sum_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SQ)
		else $error("accepted sample did not start the sequencer");

	a_middle_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		middle_q |-> start_q)
		else $error("middle found without a start");

	a_timeout_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_tout_q) |-> (out_done_q && !out_rec_q))
		else $error("timeout result malformed");

	a_warmup_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(decide_go && !warm_done) |=> (!out_done_q && !out_rec_q && out_sum_q == '0))
		else $error("result during history fill not zero");

	a_decide_loads: assert property (@(posedge clk) disable iff (!arst_n)
		decide_go |=> (out_valid_q && state_q == S_IDLE))
		else $error("decision did not load the output register");

endmodule

[bench/motion_checker.sv]
module motion_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	amsg_in_if                              smp,
	amsg_out_if                             res,
	input  logic                            cfg_wr_en,
	input  logic [amsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [amsg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              mismatches,
	output int                              pending,
	output int                              ended_count,
	output int                              timeout_count
);
	import amsg_pkg::*;

	localparam int TAPS = AVG_TAPS_DEF;

	typedef struct packed {
		logic                 done;
		logic                 tout;
		logic                 rec;
		logic [AVG_SUM_W-1:0] avg_sum;
	} motion_report_t;

	logic [THRESH_W-1:0] low_th;
	logic [THRESH_W-1:0] high_th;
	logic [THRESH_W-1:0] mid_th;
	logic [LIMIT_W-1:0]  limit;

	logic [MAG_W-1:0]    mag_hist [TAPS+1];
	int                  warm_count;
	logic                start_found;
	logic                middle_found;
	logic                seeking_low;
	logic [LIMIT_W-1:0]  rec_count;

	motion_report_t      awaited_reports [$];

	function automatic int unsigned axis_square(input logic signed [ACCEL_W-1:0] a);
		int v;
		v = int'(a);
		if (v < 0)
			v = -v;
		return v * v;
	endfunction

	// greedy bit-by-bit search for the largest root whose square fits
	function automatic logic [MAG_W-1:0] floor_root(input longint unsigned n);
		logic [MAG_W-1:0] root;
		logic [MAG_W-1:0] trial;
		longint unsigned  t;
		root = '0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			trial = root;
			trial[b] = 1'b1;
			t = 64'(trial);
			if (t * t <= n)
				root = trial;
		end
		return root;
	endfunction

	function automatic motion_report_t predict_motion(input logic signed [ACCEL_W-1:0] x,
		input logic signed [ACCEL_W-1:0] y, input logic signed [ACCEL_W-1:0] z);
		motion_report_t  r;
		longint unsigned sq;
		int unsigned     total;
		int unsigned     lo_sum;
		int unsigned     hi_sum;
		int unsigned     mid_sum;
		logic            ended;
		logic            took;
		r = '0;
		sq = 64'(axis_square(x)) + 64'(axis_square(y)) + 64'(axis_square(z));
		// history still filling: all-zero report
		if (warm_count < TAPS + 1) begin
			mag_hist[warm_count] = floor_root(sq);
			warm_count++;
			return r;
		end
		for (int i = 0; i < TAPS; i++)
			mag_hist[i] = mag_hist[i+1];
		mag_hist[TAPS] = floor_root(sq);
		total = 0;
		for (int i = 0; i < TAPS; i++)
			total += 32'(mag_hist[i]);
		lo_sum  = 32'(low_th) * 32'(TAPS);
		hi_sum  = 32'(high_th) * 32'(TAPS);
		mid_sum = 32'(mid_th) * 32'(TAPS);
		ended = 1'b0;
		took  = 1'b0;
		if (rec_count > limit) begin
			start_found  = 1'b0;
			middle_found = 1'b0;
			rec_count    = '0;
			ended        = 1'b1;
			r.tout       = 1'b1;
		end else if (!start_found) begin
			if (total <= lo_sum) begin
				start_found = 1'b1;
				seeking_low = 1'b0;
				took        = 1'b1;
			end else if (total >= hi_sum) begin
				start_found = 1'b1;
				seeking_low = 1'b1;
				took        = 1'b1;
			end
		end else if (!middle_found) begin
			took = 1'b1;
			if (seeking_low ? (total <= mid_sum) : (total >= mid_sum))
				middle_found = 1'b1;
		end else begin
			took = 1'b1;
			if (seeking_low ? (total >= mid_sum) : (total <= mid_sum)) begin
				start_found  = 1'b0;
				middle_found = 1'b0;
				ended        = 1'b1;
			end
		end
		// count saturates, so a limit of all ones never times out
		if (ended)
			rec_count = '0;
		else if (took && rec_count != COUNT_MAX)
			rec_count++;
		r.done    = ended;
		r.rec     = took;
		r.avg_sum = total[AVG_SUM_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		motion_report_t want;
		motion_report_t got;
		if (!arst_n) begin
			low_th  = LOW_THRESH_RST;
			high_th = HIGH_THRESH_RST;
			mid_th  = MID_THRESH_RST;
			limit   = TIMEOUT_RST;
			for (int i = 0; i <= TAPS; i++)
				mag_hist[i] = '0;
			warm_count    = 0;
			start_found   = 1'b0;
			middle_found  = 1'b0;
			seeking_low   = 1'b0;
			rec_count     = '0;
			mismatches    = 0;
			ended_count   = 0;
			timeout_count = 0;
			awaited_reports.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_LOW_THRESH:  low_th  = cfg_wdata;
					REG_HIGH_THRESH: high_th = cfg_wdata;
					REG_MID_THRESH:  mid_th  = cfg_wdata;
					REG_TIMEOUT:     limit   = cfg_wdata[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (smp.valid === 1'b1 && smp.ready === 1'b1)
				awaited_reports.push_back(predict_motion(smp.accel_x, smp.accel_y, smp.accel_z));
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				got = {res.motion_done, res.timed_out, res.recorded, res.average_sum};
				if (awaited_reports.size() == 0) begin
					$display("%0t: result beat with none awaited: done=%0b timeout=%0b rec=%0b sum=%0d",
						$time, got.done, got.tout, got.rec, got.avg_sum);
					mismatches++;
				end else begin
					want = awaited_reports.pop_front();
					if (got !== want) begin
						$display("%0t: expected done=%0b timeout=%0b rec=%0b sum=%0d", $time,
							want.done, want.tout, want.rec, want.avg_sum);
						$display("%0t:   actual done=%0b timeout=%0b rec=%0b sum=%0d", $time,
							got.done, got.tout, got.rec, got.avg_sum);
						mismatches++;
					end
					if (want.done)
						ended_count++;
					if (want.tout)
						timeout_count++;
				end
			end
			pending <= awaited_reports.size();
		end
	end

endmodule

[bench/tb_top.sv]
module tb_top;
	import amsg_pkg::*;

	typedef logic signed [ACCEL_W-1:0] accel_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_word_t;

	localparam int CHOKE_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int mismatches;
	int pending;
	int ended_count;
	int timeout_count;

	int samples_sent;
	int burst_left;
	int choke_ticket;
	int settings_used;
	int cur_low;
	int cur_high;
	int cur_mid;

	amsg_in_if  sample_ch ();
	amsg_out_if result_ch ();

	accel_motion_segmenter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_ch),
		.result_out (result_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	motion_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.smp           (sample_ch),
		.res           (result_ch),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.pending       (pending),
		.ended_count   (ended_count),
		.timeout_count (timeout_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

	// result side: stall pattern of its own plus one long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int open_len;
		int stall_len;
		int choke_served;
		mode_left    = 0;
		mode         = 0;
		choke_served = 0;
		result_ch.ready = 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (choke_ticket != choke_served) begin
				choke_served = choke_ticket;
				result_ch.ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end
			if (mode_left <= 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 300);
			end
			case (mode)
				0: begin
					open_len  = $urandom_range(20, 60);
					stall_len = 0;
				end
				1: begin
					open_len  = $urandom_range(1, 6);
					stall_len = $urandom_range(1, 6);
				end
				default: begin
					open_len  = $urandom_range(1, 2);
					stall_len = $urandom_range(4, 15);
				end
			endcase
			result_ch.ready <= 1'b1;
			repeat (open_len) @(posedge clk);
			if (stall_len > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
			mode_left -= open_len + stall_len;
		end
	end

	task automatic offer(input accel_t x, input accel_t y, input accel_t z);
		sample_ch.valid   <= 1'b1;
		sample_ch.accel_x <= x;
		sample_ch.accel_y <= y;
		sample_ch.accel_z <= z;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		samples_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
	endtask

	// one axis carries the level, the other two a little noise
	task automatic offer_level(input int m);
		accel_t v [3];
		int     main_axis;
		main_axis = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++)
			v[i] = accel_t'(int'($urandom_range(0, 30)) - 15);
		v[main_axis] = $urandom_range(0, 1) ? accel_t'(m) : accel_t'(-m);
		offer(v[0], v[1], v[2]);
	endtask

	function automatic int pick_level(input int lo, input int hi);
		if (lo < 0)
			lo = 0;
		if (lo > 32000)
			lo = 32000;
		if (hi < 0)
			hi = 0;
		if (hi > 32000)
			hi = 32000;
		if (lo > hi)
			return hi;
		return $urandom_range(hi, lo);
	endfunction

	task automatic level_run(input int n, input int lo, input int hi);
		repeat (n) offer_level(pick_level(lo, hi));
	endtask

	// start, middle crossing, return crossing; sometimes long or cut short
	task automatic offer_movement();
		int mid_len;
		bit from_above;
		from_above = 1'($urandom_range(0, 1));
		mid_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 70) : $urandom_range(2, 10);
		if (!from_above) begin
			level_run($urandom_range(2, 8), cur_low - 250, cur_low);
			level_run(mid_len, cur_mid + 20, cur_mid + 400);
			if ($urandom_range(0, 5) != 0)
				level_run($urandom_range(2, 8), cur_mid - 400, cur_mid - 20);
		end else begin
			level_run($urandom_range(2, 8), cur_high, cur_high + 250);
			level_run(mid_len, cur_mid - 400, cur_mid - 20);
			if ($urandom_range(0, 5) != 0)
				level_run($urandom_range(2, 8), cur_mid + 20, cur_mid + 400);
		end
	endtask

	task automatic offer_noise();
		accel_t v [3];
		repeat ($urandom_range(1, 5)) begin
			for (int i = 0; i < 3; i++) begin
				case ($urandom_range(0, 7))
					0:       v[i] = 16'sh8000;
					1:       v[i] = 16'sh7fff;
					2:       v[i] = '0;
					3:       v[i] = '1;
					default: v[i] = accel_t'($urandom);
				endcase
			end
			offer(v[0], v[1], v[2]);
		end
	endtask

	// hold input low until every result is back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(input int lo, input int hi, input int mid, input int lim);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_LOW_THRESH;
		cfg_wdata <= cfg_word_t'(lo);
		@(posedge clk);
		cfg_index <= REG_HIGH_THRESH;
		cfg_wdata <= cfg_word_t'(hi);
		@(posedge clk);
		cfg_index <= REG_MID_THRESH;
		cfg_wdata <= cfg_word_t'(mid);
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_wdata <= cfg_word_t'(lim);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input int lo, input int hi, input int mid, input int lim,
		input int quota, input bit choke);
		int first;
		drain();
		program_regs(lo, hi, mid, lim);
		cur_low  = lo;
		cur_high = hi;
		cur_mid  = mid;
		settings_used++;
		first = samples_sent;
		while (samples_sent - first < quota) begin
			// starve the result side while samples keep coming
			if (choke && samples_sent - first >= 10) begin
				choke = 1'b0;
				choke_ticket <= choke_ticket + 1;
			end
			case ($urandom_range(0, 19)) inside
				[0:2]:   level_run($urandom_range(2, 10), cur_low + 1, cur_high - 1);
				[3:5]:   offer_noise();
				default: offer_movement();
			endcase
		end
	endtask

	initial begin
		int rl;
		int rm;
		int rh;
		samples_sent  = 0;
		burst_left    = 0;
		choke_ticket  = 0;
		settings_used = 1;
		cur_low  = int'(LOW_THRESH_RST);
		cur_high = int'(HIGH_THRESH_RST);
		cur_mid  = int'(MID_THRESH_RST);
		sample_ch.valid   = 1'b0;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes fill the history, then one short movement at reset values
		offer(16'sh8000, 16'sh8000, 16'sh8000);
		offer(16'sh7fff, 16'sh7fff, 16'sh7fff);
		offer('0, '0, '0);
		offer('1, '1, '1);
		offer(16'sh7fff, 16'sh8000, '0);
		offer(16'sh8000, '0, 16'sh7fff);
		offer('0, 16'sd1, '1);
		level_run(4, 700, 800);
		level_run(5, 1200, 1300);
		level_run(5, 700, 800);

		run_phase(int'(LOW_THRESH_RST), int'(HIGH_THRESH_RST), int'(MID_THRESH_RST),
			int'(TIMEOUT_RST), 120, 1'b1);
		run_phase(0, 65535, 0, 0, 40, 1'b0);
		// never finds the middle: the count must saturate without a timeout
		run_phase(65535, 0, 65535, 255, 280, 1'b0);
		rl = $urandom_range(300, 2000);
		rm = rl + $urandom_range(50, 1000);
		rh = rm + $urandom_range(50, 1000);
		run_phase(rl, rh, rm, $urandom_range(4, 40), 100, 1'b0);
		run_phase(900, 1100, 1000, 3, 60, 1'b0);
		run_phase(1000, 1000, 1000, 255, 40, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		$display("run covered %0d samples under %0d register settings", samples_sent,
			settings_used);
		$display("%0d movements reported done, %0d of them by timeout", ended_count,
			timeout_count);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[accel_motion_segmenter_top.f]
src/amsg_pkg.sv
src/amsg_if.sv
src/accel_motion_segmenter_top.sv
bench/motion_checker.sv
bench/tb_top.sv
